// ===== rtl/core/skbs_pkg.sv =====
// Shared types and constants for the sorted key table search block.
package skbs_pkg;

    localparam int KEY_W   = 64;
    localparam int LAT_W   = 38;
    localparam int LON_W   = 39;
    localparam int CNT_W   = 13;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 96;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_FIND   = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_APPENDED  = 3'd0,
        STAT_FOUND     = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_ORDER     = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_FAILED    = 3'd5,
        STAT_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_PROBE,
        SEQ_CHECK
    } seq_state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        entry_t wr_data;
    } table_wr_t;

endpackage

// ===== rtl/core/sorted_key_table_binary_search.sv =====
// Append, clear and unused codes give their result in the cycle after the input transfer.
// A find moves from IDLE to PROBE, then alternates PROBE (table read) and CHECK (compare)
// until a key match or an empty range gives the result.
// One item at a time: s_tready is high only when idle with the result register empty, so
// a new item is taken only after the previous result has been transferred.
// Reset clears count, order state, failure flag and sequencer; table contents stay undefined.
module sorted_key_table_binary_search #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_id [63:0], lat_in [101:64], lon_in [140:102], zero fill
    input  logic [skbs_pkg::S_DATA_W-1:0]   s_tdata,
    // func [1:0]
    input  logic [skbs_pkg::FUNC_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // lat_out [37:0], lon_out [76:38], entry_count [89:77], zero fill
    output logic [skbs_pkg::M_DATA_W-1:0]   m_tdata,
    // status [2:0]
    output logic [skbs_pkg::STAT_W-1:0]     m_tuser
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PAD_W = skbs_pkg::M_DATA_W - skbs_pkg::LAT_W - skbs_pkg::LON_W
                           - skbs_pkg::CNT_W;

    skbs_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] filled_reg, filled_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic signed [skbs_pkg::KEY_W-1:0] key_reg, key_next;
    logic signed [skbs_pkg::KEY_W-1:0] prev_key_reg, prev_key_next;
    logic have_prev_reg, have_prev_next;
    logic failed_reg, failed_next;

    logic m_tvalid_reg, m_tvalid_next;
    skbs_pkg::status_t m_status_reg, m_status_next;
    logic signed [skbs_pkg::LAT_W-1:0] m_lat_reg, m_lat_next;
    logic signed [skbs_pkg::LON_W-1:0] m_lon_reg, m_lon_next;
    logic [skbs_pkg::CNT_W-1:0] m_count_reg, m_count_next;

    skbs_pkg::entry_t in_entry;
    skbs_pkg::func_t in_func;
    skbs_pkg::table_wr_t tbl_wr;
    skbs_pkg::entry_t rd_data;
    logic [CW-1:0] mid_full;
    logic in_xfer;

    assign in_entry.key = s_tdata[63:0];
    assign in_entry.lat = s_tdata[101:64];
    assign in_entry.lon = s_tdata[140:102];
    assign in_func      = skbs_pkg::func_t'(s_tuser);

    assign s_tready = (state_reg == skbs_pkg::SEQ_IDLE) && !m_tvalid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // midpoint = left + (right - left) / 2, below the fill count whenever left < right
    assign mid_full = left_reg + ((right_reg - left_reg) >> 1);

    skbs_table #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .wr_addr (filled_reg[AW-1:0]),
        .rd_addr (mid_full[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        prev_key_next  = prev_key_reg;
        have_prev_next = have_prev_reg;
        failed_next    = failed_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_lat_next     = m_lat_reg;
        m_lon_next     = m_lon_reg;
        m_count_next   = m_count_reg;
        tbl_wr.wr_en   = 1'b0;
        tbl_wr.wr_data = in_entry;

        case (state_reg)
            skbs_pkg::SEQ_IDLE: begin
                if (in_xfer) begin
                    m_lat_next    = '0;
                    m_lon_next    = '0;
                    m_tvalid_next = 1'b1;
                    m_status_next = skbs_pkg::STAT_NOT_FOUND;
                    case (in_func)
                        skbs_pkg::FUNC_APPEND: begin
                            if (failed_reg) begin
                                m_status_next = skbs_pkg::STAT_FAILED;
                            end else if (have_prev_reg && (in_entry.key < prev_key_reg)) begin
                                failed_next   = 1'b1;
                                m_status_next = skbs_pkg::STAT_ORDER;
                            end else if (filled_reg >= CW'(TABLE_ENTRIES)) begin
                                failed_next   = 1'b1;
                                m_status_next = skbs_pkg::STAT_FULL;
                            end else begin
                                tbl_wr.wr_en   = 1'b1;
                                filled_next    = filled_reg + 1'b1;
                                prev_key_next  = in_entry.key;
                                have_prev_next = 1'b1;
                                m_status_next  = skbs_pkg::STAT_APPENDED;
                            end
                        end
                        skbs_pkg::FUNC_FIND: begin
                            m_tvalid_next = 1'b0;
                            key_next      = in_entry.key;
                            left_next     = '0;
                            right_next    = filled_reg;
                            state_next    = skbs_pkg::SEQ_PROBE;
                        end
                        skbs_pkg::FUNC_CLEAR: begin
                            filled_next    = '0;
                            prev_key_next  = '0;
                            have_prev_next = 1'b0;
                            failed_next    = 1'b0;
                            m_status_next  = skbs_pkg::STAT_CLEARED;
                        end
                        default: begin
                            m_status_next = skbs_pkg::STAT_NOT_FOUND;
                        end
                    endcase
                    m_count_next = skbs_pkg::CNT_W'(filled_next);
                end
            end
            skbs_pkg::SEQ_PROBE: begin
                // table read at the midpoint is issued this cycle
                if (left_reg < right_reg) begin
                    mid_next   = mid_full[AW-1:0];
                    state_next = skbs_pkg::SEQ_CHECK;
                end else begin
                    m_tvalid_next = 1'b1;
                    m_status_next = skbs_pkg::STAT_NOT_FOUND;
                    state_next    = skbs_pkg::SEQ_IDLE;
                end
            end
            skbs_pkg::SEQ_CHECK: begin
                if (rd_data.key == key_reg) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = skbs_pkg::STAT_FOUND;
                    m_lat_next    = rd_data.lat;
                    m_lon_next    = rd_data.lon;
                    state_next    = skbs_pkg::SEQ_IDLE;
                end else begin
                    if (rd_data.key < key_reg) begin
                        left_next = CW'(mid_reg) + 1'b1;
                    end else begin
                        right_next = CW'(mid_reg);
                    end
                    state_next = skbs_pkg::SEQ_PROBE;
                end
            end
            default: begin
                state_next = skbs_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skbs_pkg::SEQ_IDLE;
            filled_reg    <= '0;
            prev_key_reg  <= '0;
            have_prev_reg <= 1'b0;
            failed_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            prev_key_reg  <= prev_key_next;
            have_prev_reg <= have_prev_next;
            failed_reg    <= failed_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_lat_reg    <= m_lat_next;
        m_lon_reg    <= m_lon_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_count_reg, m_lon_reg, m_lat_reg};

endmodule

// ===== rtl/core/skbs_table.sv =====
// Record store: one write port, one registered read port.
module skbs_table #(
    parameter int ENTRIES = 4096,
    parameter int AW      = 12
) (
    input  logic                  aclk,
    input  skbs_pkg::table_wr_t   wr,
    input  logic [AW-1:0]         wr_addr,
    input  logic [AW-1:0]         rd_addr,
    output skbs_pkg::entry_t      rd_data
);

    skbs_pkg::entry_t mem [ENTRIES];
    skbs_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            mem[wr_addr] <= wr.wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the sorted key table: stream stimulus, table predictor and reply checks.
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_ENTRIES = 4096;
    localparam int END_DRAIN = 40;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_TAIL = 200;

    localparam longint KEY_MIN = 64'sh8000_0000_0000_0000;
    localparam longint KEY_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint LAT_MIN = -64'sd90000000000;
    localparam longint LAT_MAX = 64'sd90000000000;
    localparam longint LON_MIN = -64'sd180000000000;
    localparam longint LON_MAX = 64'sd180000000000;

    typedef struct {
        skbs_pkg::status_t                 status;
        logic signed [skbs_pkg::LAT_W-1:0] lat;
        logic signed [skbs_pkg::LON_W-1:0] lon;
        logic [skbs_pkg::CNT_W-1:0]        count;
    } reply_t;

    // Holds its own copy of the point table and predicts one reply per request.
    class point_lookup_board #(int DEPTH = 4096);
        logic signed [skbs_pkg::KEY_W-1:0] key_mem [DEPTH];
        logic signed [skbs_pkg::LAT_W-1:0] lat_mem [DEPTH];
        logic signed [skbs_pkg::LON_W-1:0] lon_mem [DEPTH];
        int                                fill_count;
        logic signed [skbs_pkg::KEY_W-1:0] last_key;
        bit                                have_last;
        bit                                build_bad;
        reply_t                            pending_replies[$];
        int                                error_count;
        int                                reply_idx;

        function new();
            fill_count  = 0;
            last_key    = '0;
            have_last   = 0;
            build_bad   = 0;
            error_count = 0;
            reply_idx   = 0;
        endfunction

        function void note_request(skbs_pkg::func_t f,
                                   logic signed [skbs_pkg::KEY_W-1:0] key,
                                   logic signed [skbs_pkg::LAT_W-1:0] lat,
                                   logic signed [skbs_pkg::LON_W-1:0] lon);
            reply_t r;
            int     lo;
            int     hi;
            int     mid;
            bit     hit;
            r.status = skbs_pkg::STAT_NOT_FOUND;
            r.lat    = '0;
            r.lon    = '0;
            case (f)
                skbs_pkg::FUNC_APPEND: begin
                    if (build_bad) begin
                        r.status = skbs_pkg::STAT_FAILED;
                    end else if (have_last && key < last_key) begin
                        build_bad = 1;
                        r.status  = skbs_pkg::STAT_ORDER;
                    end else if (fill_count >= DEPTH) begin
                        build_bad = 1;
                        r.status  = skbs_pkg::STAT_FULL;
                    end else begin
                        key_mem[fill_count] = key;
                        lat_mem[fill_count] = lat;
                        lon_mem[fill_count] = lon;
                        fill_count++;
                        last_key  = key;
                        have_last = 1;
                        r.status  = skbs_pkg::STAT_APPENDED;
                    end
                end
                skbs_pkg::FUNC_FIND: begin
                    lo  = 0;
                    hi  = fill_count;
                    hit = 0;
                    while (lo < hi && !hit) begin
                        mid = lo + (hi - lo) / 2;
                        if (key_mem[mid] == key) begin
                            hit      = 1;
                            r.status = skbs_pkg::STAT_FOUND;
                            r.lat    = lat_mem[mid];
                            r.lon    = lon_mem[mid];
                        end else if (key_mem[mid] < key) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid;
                        end
                    end
                end
                skbs_pkg::FUNC_CLEAR: begin
                    fill_count = 0;
                    last_key   = '0;
                    have_last  = 0;
                    build_bad  = 0;
                    r.status   = skbs_pkg::STAT_CLEARED;
                end
                default: ;
            endcase
            r.count = fill_count[skbs_pkg::CNT_W-1:0];
            pending_replies.push_back(r);
        endfunction

        task report_mismatch(string msg);
            error_count++;
            $display("[%0t] mismatch on reply %0d: %s", $time, reply_idx, msg);
        endtask

        task check_reply(logic [skbs_pkg::STAT_W-1:0] st,
                         logic signed [skbs_pkg::LAT_W-1:0] lat,
                         logic signed [skbs_pkg::LON_W-1:0] lon,
                         logic [skbs_pkg::CNT_W-1:0] cnt);
            reply_t want;
            if (pending_replies.size() == 0) begin
                report_mismatch("reply transfer with nothing outstanding");
            end else begin
                want = pending_replies.pop_front();
                if (st !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, want.status));
                if (lat !== want.lat)
                    report_mismatch($sformatf("lat_out %0d, want %0d", lat, want.lat));
                if (lon !== want.lon)
                    report_mismatch($sformatf("lon_out %0d, want %0d", lon, want.lon));
                if (cnt !== want.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d", cnt, want.count));
            end
            reply_idx++;
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [skbs_pkg::S_DATA_W-1:0]   s_tdata;
    logic [skbs_pkg::FUNC_W-1:0]     s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [skbs_pkg::M_DATA_W-1:0]   m_tdata;
    logic [skbs_pkg::STAT_W-1:0]     m_tuser;

    point_lookup_board #(TABLE_ENTRIES) board;
    bit send_gaps;
    bit recv_stalls;
    int sent_items;

    sorted_key_table_binary_search #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #(64'd15_000_000);
        $display("tb_top failed");
        $finish;
    end

    function automatic longint unsigned rand_u64();
        return {$urandom, $urandom};
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned span;
        span = longint'(hi - lo) + 1;
        return lo + longint'(rand_u64() % span);
    endfunction

    function automatic longint rand_lat();
        case ($urandom_range(0, 7))
            0: return LAT_MIN;
            1: return LAT_MAX;
            default: return rand_between(LAT_MIN, LAT_MAX);
        endcase
    endfunction

    function automatic longint rand_lon();
        case ($urandom_range(0, 7))
            0: return LON_MIN;
            1: return LON_MAX;
            default: return rand_between(LON_MIN, LON_MAX);
        endcase
    endfunction

    // mode 0: full range, mode 1: narrow band with many duplicates, mode 2: near the ends
    function automatic longint pick_key(int mode);
        case (mode)
            1: return longint'($urandom_range(0, 40)) - 20;
            2: begin
                if ($urandom_range(0, 1) == 0)
                    return KEY_MIN + longint'($urandom_range(0, 50));
                else
                    return KEY_MAX - longint'($urandom_range(0, 50));
            end
            default: return longint'(rand_u64());
        endcase
    endfunction

    // Drives one transfer on the input channel; valid stays high into the next call
    // unless that call opens with a gap.
    task automatic send_item(skbs_pkg::func_t f, longint key, longint lat, longint lon);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {3'b000, lon[skbs_pkg::LON_W-1:0], lat[skbs_pkg::LAT_W-1:0], key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(f, key, lat[skbs_pkg::LAT_W-1:0], lon[skbs_pkg::LON_W-1:0]);
        sent_items++;
    endtask

    task automatic send_append(longint key);
        send_item(skbs_pkg::FUNC_APPEND, key, rand_lat(), rand_lon());
    endtask

    task automatic send_find(longint key);
        send_item(skbs_pkg::FUNC_FIND, key, rand_lat(), rand_lon());
    endtask

    task automatic send_find_probe();
        int     r;
        longint k;
        r = $urandom_range(0, 4);
        if (board.fill_count > 0 && r < 4)
            k = board.key_mem[$urandom_range(0, board.fill_count - 1)];
        else
            k = longint'(rand_u64());
        // neighbors of stored keys may land between entries
        if (r == 3)
            k = ($urandom_range(0, 1) == 0) ? k + 1 : k - 1;
        send_find(k);
    endtask

    task automatic run_table_phase();
        longint keys[$];
        int     n;
        int     mode;
        longint k;
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 7) != 0)
            send_item(skbs_pkg::FUNC_CLEAR, longint'(rand_u64()), rand_lat(), rand_lon());
        for (int i = 0; i < n; i++)
            keys.push_back(pick_key(mode));
        keys.sort();
        foreach (keys[i]) begin
            k = keys[i];
            if (board.have_last && k < board.last_key)
                k = board.last_key;
            send_append(k);
            if ($urandom_range(0, 3) == 0)
                send_find_probe();
        end
        repeat ($urandom_range(1, 12)) send_find_probe();
        if ($urandom_range(0, 4) == 0) begin
            // broken sequence: a key below the last one where there is one, then appends that must bounce
            if (board.have_last && board.last_key != KEY_MIN)
                send_append(board.last_key - longint'($urandom_range(1, 3)));
            else
                send_append(longint'(rand_u64()));
            repeat ($urandom_range(0, 3)) send_append(KEY_MAX);
            repeat ($urandom_range(0, 3)) send_find_probe();
        end
        if ($urandom_range(0, 9) == 0)
            send_item(skbs_pkg::FUNC_NONE, longint'(rand_u64()), rand_lat(), rand_lon());
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_reply(m_tuser, m_tdata[skbs_pkg::LAT_W-1:0],
                              m_tdata[skbs_pkg::LAT_W+skbs_pkg::LON_W-1:skbs_pkg::LAT_W],
                              m_tdata[skbs_pkg::LAT_W+skbs_pkg::LON_W+skbs_pkg::CNT_W-1:
                                      skbs_pkg::LAT_W+skbs_pkg::LON_W]);
    end

    // result side back-pressure
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (recv_stalls && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int random_base;
        board       = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = skbs_pkg::FUNC_APPEND;
        send_gaps   = 0;
        recv_stalls = 0;
        sent_items  = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, unused code, extremes, duplicates, order error, clear
        send_find(0);
        send_item(skbs_pkg::FUNC_NONE, KEY_MAX, LAT_MAX, LON_MAX);
        send_item(skbs_pkg::FUNC_APPEND, KEY_MIN, LAT_MIN, LON_MIN);
        send_item(skbs_pkg::FUNC_APPEND, -5, LAT_MAX, LON_MAX);
        send_item(skbs_pkg::FUNC_APPEND, -5, -1, -1);
        send_item(skbs_pkg::FUNC_APPEND, 0, 0, 0);
        send_append(KEY_MAX);
        send_find(KEY_MIN);
        send_find(-5);
        send_find(KEY_MAX);
        send_find(7);
        send_find(0);
        send_item(skbs_pkg::FUNC_NONE, -5, LAT_MIN, LON_MIN);
        send_append(3);
        send_append(KEY_MAX);
        send_find(-5);
        send_find(KEY_MAX - 1);
        send_item(skbs_pkg::FUNC_CLEAR, KEY_MIN, LAT_MIN, LON_MIN);
        send_find(-5);
        send_append(-1);
        send_append(KEY_MIN + 1);
        send_append(5);
        send_item(skbs_pkg::FUNC_CLEAR, 0, 0, 0);

        random_base = sent_items;
        while (sent_items - random_base < RANDOM_ITEMS) begin
            if (sent_items - random_base > RANDOM_ITEMS - QUIET_TAIL) begin
                send_gaps   = 0;
                recv_stalls = 0;
            end else begin
                send_gaps   = ($urandom_range(0, 3) != 0);
                recv_stalls = ($urandom_range(0, 3) != 0);
            end
            run_table_phase();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge aclk);
        repeat (END_DRAIN) @(posedge aclk);
        if (board.error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
